// ===== rtl/rc4_pkg.sv =====
package rc4_pkg;

  // Permutation table geometry (fixed by the cipher)
  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned PERM_AW    = 8;

  // Key store
  localparam int unsigned MAX_KEY_BYTES = 256;
  localparam int unsigned KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned LEN_W  = 9;
  localparam logic [LEN_W-1:0] KEY_LEN_RESET = LEN_W'(16);

  // Request kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_SCHED = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  // Result kinds
  localparam logic RES_DATA = 1'b0;
  localparam logic RES_DONE = 1'b1;

  // Datapath commands, one per controller step
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_FILL,
    CMD_KSA_RD,
    CMD_KSA_J,
    CMD_KSA_WK,
    CMD_KSA_WJ,
    CMD_DAT_RD,
    CMD_DAT_J,
    CMD_DAT_WI,
    CMD_DAT_WJ,
    CMD_DAT_KS,
    CMD_EMIT_DATA,
    CMD_EMIT_DONE
  } cmd_e;

  typedef struct packed {
    logic k_last;    // schedule counter at its last entry
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

// ===== rtl/rc4_in_if.sv =====
interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] key_index;
  logic [7:0] key_byte;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output key_index, output key_byte,
                  output data_byte, input ready);
  modport sink   (input valid, input kind, input key_index, input key_byte,
                  input data_byte, output ready);
endinterface

// ===== rtl/rc4_out_if.sv =====
interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] out_byte;

  modport source (output valid, output result_kind, output out_byte, input ready);
  modport sink   (input valid, input result_kind, input out_byte, output ready);
endinterface

// ===== rtl/rc4_ram.sv =====
module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned Aw = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rc4_ctrl.sv =====
module rc4_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       kind_i,
  input  rc4_pkg::status_t status_i,
  output logic             ready_o,
  output rc4_pkg::cmd_e    cmd_o
);
  import rc4_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KSA_RD,
    ST_KSA_J,
    ST_KSA_WK,
    ST_KSA_WJ,
    ST_DAT_RD,
    ST_DAT_J,
    ST_DAT_WI,
    ST_DAT_WJ,
    ST_DAT_KS,
    ST_WAIT,
    ST_EMIT
  } state_e;

  state_e state_q;
  cmd_e   cmd_q;
  logic   ready_q;
  logic   sched_q;  // current request is a key schedule

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= CMD_NONE;
      ready_q <= 1'b1;
      sched_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept_i && (kind_i == KIND_SCHED)) begin
            state_q <= ST_FILL;
            cmd_q   <= CMD_FILL;
            ready_q <= 1'b0;
            sched_q <= 1'b1;
          end else if (accept_i && (kind_i == KIND_DATA)) begin
            state_q <= ST_DAT_RD;
            cmd_q   <= CMD_DAT_RD;
            ready_q <= 1'b0;
            sched_q <= 1'b0;
          end
        end
        ST_FILL: begin
          if (status_i.k_last) begin
            state_q <= ST_KSA_RD;
            cmd_q   <= CMD_KSA_RD;
          end
        end
        ST_KSA_RD: begin
          state_q <= ST_KSA_J;
          cmd_q   <= CMD_KSA_J;
        end
        ST_KSA_J: begin
          state_q <= ST_KSA_WK;
          cmd_q   <= CMD_KSA_WK;
        end
        ST_KSA_WK: begin
          state_q <= ST_KSA_WJ;
          cmd_q   <= CMD_KSA_WJ;
        end
        ST_KSA_WJ: begin
          if (status_i.k_last) begin
            state_q <= ST_WAIT;
            cmd_q   <= CMD_NONE;
          end else begin
            state_q <= ST_KSA_RD;
            cmd_q   <= CMD_KSA_RD;
          end
        end
        ST_DAT_RD: begin
          state_q <= ST_DAT_J;
          cmd_q   <= CMD_DAT_J;
        end
        ST_DAT_J: begin
          state_q <= ST_DAT_WI;
          cmd_q   <= CMD_DAT_WI;
        end
        ST_DAT_WI: begin
          state_q <= ST_DAT_WJ;
          cmd_q   <= CMD_DAT_WJ;
        end
        ST_DAT_WJ: begin
          state_q <= ST_DAT_KS;
          cmd_q   <= CMD_DAT_KS;
        end
        ST_DAT_KS: begin
          state_q <= ST_WAIT;
          cmd_q   <= CMD_NONE;
        end
        ST_WAIT: begin
          // output register is only ever filled from here, so free stays free
          if (status_i.out_free) begin
            state_q <= ST_EMIT;
            cmd_q   <= sched_q ? CMD_EMIT_DONE : CMD_EMIT_DATA;
          end
        end
        ST_EMIT: begin
          state_q <= ST_IDLE;
          cmd_q   <= CMD_NONE;
          ready_q <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
          cmd_q   <= CMD_NONE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign ready_o = ready_q;
  assign cmd_o   = cmd_q;

`ifndef NO_ASSERTIONS
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (state_q == ST_IDLE))
    else $error("ready raised outside idle");

  a_emit_after_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> ($past(state_q) == ST_WAIT))
    else $error("emit not preceded by wait");
`endif

endmodule

// ===== rtl/rc4_dp.sv =====
module rc4_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [1:0]                 kind_i,
  input  logic [7:0]                 key_index_i,
  input  logic [7:0]                 key_byte_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       cfg_we_i,
  input  logic [rc4_pkg::LEN_W-1:0]  cfg_wdata_i,
  input  rc4_pkg::cmd_e              cmd_i,
  input  logic                       out_ready_i,
  output rc4_pkg::status_t           status_o,
  output logic                       out_valid_o,
  output logic                       result_kind_o,
  output logic [7:0]                 out_byte_o
);
  import rc4_pkg::*;

  logic [PERM_AW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [KEY_AW-1:0]  kpos_q, kpos_d, kpos_nxt;
  logic [LEN_W-1:0]   key_length_q, eff_len, kpos_inc;
  logic [7:0]         si_q, si_d, sj_q, sj_d, data_q;
  logic               out_valid_q, out_valid_d, result_kind_q;
  logic [7:0]         out_byte_q;
  logic               load_out;

  logic               p_we, p_re;
  logic [PERM_AW-1:0] p_waddr, p_raddr;
  logic [7:0]         p_wdata, p_rdata;
  logic               k_we, k_re;
  logic [KEY_AW-1:0]  k_waddr, k_raddr;
  logic [7:0]         k_rdata;
  logic               start_sched;

  rc4_ram #(.WIDTH(8), .DEPTH(PERM_DEPTH)) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  rc4_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (key_byte_i),
    .re_i    (k_re),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  // zero length acts as one, oversize saturates
  always_comb begin
    if (key_length_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (key_length_q > LEN_W'(MAX_KEY_BYTES)) begin
      eff_len = LEN_W'(MAX_KEY_BYTES);
    end else begin
      eff_len = key_length_q;
    end
  end

  assign kpos_inc = LEN_W'(kpos_q) + LEN_W'(1);
  assign kpos_nxt = (kpos_inc >= eff_len) ? '0 : kpos_inc[KEY_AW-1:0];

  assign k_we    = accept_i && (kind_i == KIND_LOAD)
                   && (LEN_W'(key_index_i) < LEN_W'(MAX_KEY_BYTES));
  assign k_waddr = key_index_i[KEY_AW-1:0];
  assign start_sched = accept_i && (kind_i == KIND_SCHED);

  always_comb begin
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    kpos_d   = kpos_q;
    si_d     = si_q;
    sj_d     = sj_q;
    p_we     = 1'b0;
    p_waddr  = k_q;
    p_wdata  = k_q;
    p_re     = 1'b0;
    p_raddr  = k_q;
    k_re     = 1'b0;
    k_raddr  = kpos_q;
    load_out = 1'b0;
    unique case (cmd_i)
      CMD_NONE: ;
      CMD_FILL: begin
        p_we = 1'b1;
        k_d  = k_q + 1'b1;
      end
      CMD_KSA_RD: begin
        p_re = 1'b1;
        k_re = 1'b1;
      end
      CMD_KSA_J: begin
        j_d     = j_q + p_rdata + k_rdata;
        si_d    = p_rdata;
        p_re    = 1'b1;
        p_raddr = j_d;
      end
      CMD_KSA_WK: begin
        sj_d    = p_rdata;
        p_we    = 1'b1;
        p_wdata = p_rdata;
      end
      CMD_KSA_WJ: begin
        p_we    = 1'b1;
        p_waddr = j_q;
        p_wdata = si_q;
        k_d     = k_q + 1'b1;
        kpos_d  = kpos_nxt;
      end
      CMD_DAT_RD: begin
        i_d     = i_q + 1'b1;
        p_re    = 1'b1;
        p_raddr = i_d;
      end
      CMD_DAT_J: begin
        si_d    = p_rdata;
        j_d     = j_q + p_rdata;
        p_re    = 1'b1;
        p_raddr = j_d;
      end
      CMD_DAT_WI: begin
        sj_d    = p_rdata;
        p_we    = 1'b1;
        p_waddr = i_q;
        p_wdata = p_rdata;
      end
      CMD_DAT_WJ: begin
        p_we    = 1'b1;
        p_waddr = j_q;
        p_wdata = si_q;
      end
      CMD_DAT_KS: begin
        p_re    = 1'b1;
        p_raddr = si_q + sj_q;
      end
      CMD_EMIT_DATA: load_out = 1'b1;
      CMD_EMIT_DONE: begin
        load_out = 1'b1;
        j_d      = '0;  // schedule borrowed j, stream starts from zero
      end
      default: ;
    endcase
    if (start_sched) begin
      i_d    = '0;
      j_d    = '0;
      k_d    = '0;
      kpos_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      kpos_q       <= '0;
      key_length_q <= KEY_LEN_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      kpos_q      <= kpos_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        key_length_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    si_q <= si_d;
    sj_q <= sj_d;
    if (accept_i && (kind_i == KIND_DATA)) begin
      data_q <= data_byte_i;
    end
    if (load_out) begin
      result_kind_q <= (cmd_i == CMD_EMIT_DONE) ? RES_DONE : RES_DATA;
      out_byte_q    <= (cmd_i == CMD_EMIT_DONE) ? 8'h00 : (data_q ^ p_rdata);
    end
  end

  assign status_o.k_last   = (k_q == '1);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = result_kind_q;
  assign out_byte_o        = out_byte_q;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !out_valid_q)
    else $error("result register overwritten");

  a_perm_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(p_we && p_re))
    else $error("permutation read and write in one cycle");

  a_kpos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_KSA_RD) |-> (LEN_W'(kpos_q) < eff_len))
    else $error("key position beyond key length");
`endif

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// Channel   Dir  Handshake          Payload
// in_i      in   valid/ready        kind, key_index, key_byte, data_byte
// out_o     out  valid/ready        result_kind, out_byte
// cfg       in   cfg_we_i only      cfg_wdata_i = key_length (9 bits)
//
// Key load: written when accepted, no result. Data byte: read, index update + read,
//   two write-backs, keystream read, wait, emit; serialised by the dependent reads
//   and swap on one RAM port, with ready low until the emit. Schedule: 256 identity
//   writes, 4 steps per key entry (read, update + read, 2 write-backs), wait, emit.
// Reset clears i, j, k, kpos, key_length (to 16) and the result valid flag, not the RAMs.
// A held result stalls the next data byte or schedule in its wait step.
module rc4_stream_cipher (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rc4_in_if.sink                    in_i,
  rc4_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [rc4_pkg::LEN_W-1:0] cfg_wdata_i
);
  import rc4_pkg::*;

  logic    accept;
  logic    ready;
  cmd_e    cmd;
  status_t status;

  // a request moves when both sides agree
  assign accept   = in_i.valid && ready;
  assign in_i.ready = ready;

  // sequencer: walks fill, key pass and per-byte steps
  rc4_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .kind_i   (in_i.kind),
    .status_i (status),
    .ready_o  (ready),
    .cmd_o    (cmd)
  );

  // tables, indexes, key length register and the result register
  rc4_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .kind_i        (in_i.kind),
    .key_index_i   (in_i.key_index),
    .key_byte_i    (in_i.key_byte),
    .data_byte_i   (in_i.data_byte),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .out_ready_i   (out_o.ready),
    .status_o      (status),
    .out_valid_o   (out_o.valid),
    .result_kind_o (out_o.result_kind),
    .out_byte_o    (out_o.out_byte)
  );

endmodule
